/* design/llm_pkg.sv */
package llm_pkg;

	localparam int DEPTH = 32;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IW = $clog2(DEPTH + 1);
	localparam logic [IW-1:0] NIL = IW'(DEPTH);

	localparam logic [2:0] OP_INSERT = 3'd0;
	localparam logic [2:0] OP_APPEND = 3'd1;
	localparam logic [2:0] OP_REMOVE = 3'd2;
	localparam logic [2:0] OP_TRAVERSE = 3'd3;
	localparam logic [2:0] OP_CLEAR = 3'd4;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	// one read and one write per memory per cycle
	typedef struct packed {
		logic re;
		logic [IW-1:0] raddr;
		logic vwe;
		logic [IW-1:0] vaddr;
		logic [31:0] vdata;
		logic lwe;
		logic [IW-1:0] laddr;
		logic [IW-1:0] ldata;
	} mem_req_t;

	function automatic logic is_slot(input logic [IW-1:0] idx);
		return idx < NIL;
	endfunction

endpackage

/* design/llm_store.sv */
module llm_store (
	input logic clk,
	input logic arst_n,
	input llm_pkg::mem_req_t req,
	output logic [31:0] value_rdata,
	output logic [llm_pkg::IW-1:0] link_rdata
);
	import llm_pkg::*;

	logic [31:0] vmem [DEPTH];
	logic [IW-1:0] lmem [DEPTH];
	logic [DEPTH-1:0] lvalid_q;
	logic [31:0] value_rd_q;
	logic [IW-1:0] link_rd_q;

	always_ff @(posedge clk) begin
		if (req.vwe) begin
			vmem[req.vaddr[AW-1:0]] <= req.vdata;
		end
		if (req.lwe) begin
			lmem[req.laddr[AW-1:0]] <= req.ldata;
		end
	end

	// an unwritten link slot reads as its reset chain: the next slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvalid_q <= '0;
		end else if (req.lwe) begin
			lvalid_q[req.laddr[AW-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			value_rd_q <= vmem[req.raddr[AW-1:0]];
			link_rd_q <= lvalid_q[req.raddr[AW-1:0]] ? lmem[req.raddr[AW-1:0]]
				: req.raddr + IW'(1);
		end
	end

	assign value_rdata = value_rd_q;
	assign link_rdata = link_rd_q;

endmodule

/* design/llm_ctrl.sv */
module llm_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [2:0] opcode,
	input logic signed [31:0] key,
	input logic signed [31:0] new_value,
	output llm_pkg::mem_req_t req,
	input logic [31:0] value_rdata,
	input logic [llm_pkg::IW-1:0] link_rdata,
	output logic res_valid,
	input logic res_ready,
	output logic [31:0] res_value,
	output logic [1:0] res_status,
	output logic res_last
);
	import llm_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DISPATCH = 3'd1;
	localparam logic [2:0] S_ALLOC_WR = 3'd2;
	localparam logic [2:0] S_WALK = 3'd3;
	localparam logic [2:0] S_INS_LINK = 3'd4;
	localparam logic [2:0] S_TAIL_LINK = 3'd5;
	localparam logic [2:0] S_REM_FREE = 3'd6;
	localparam logic [2:0] S_RESP = 3'd7;

	logic [2:0] state_q, state_d;
	logic [2:0] op_q, op_d;
	logic [31:0] key_q, key_d, nv_q, nv_d;
	logic [IW-1:0] head_q, head_d, tail_q, tail_d, free_q, free_d;
	logic [IW-1:0] cur_q, cur_d, prev_q, prev_d, slot_q, slot_d, cnt_q, cnt_d;
	logic [1:0] status_q, status_d;
	logic match, walk_end, fin;

	// shared comparator of the walk
	assign match = value_rdata == key_q;
	assign walk_end = !is_slot(cur_q) || (cnt_q == NIL);
	assign fin = !is_slot(link_rdata) || ((cnt_q + IW'(1)) >= NIL);
	assign in_ready = state_q == S_IDLE;

	always_comb begin
		state_d = state_q;
		op_d = op_q;
		key_d = key_q;
		nv_d = nv_q;
		head_d = head_q;
		tail_d = tail_q;
		free_d = free_q;
		cur_d = cur_q;
		prev_d = prev_q;
		slot_d = slot_q;
		cnt_d = cnt_q;
		status_d = status_q;
		req = '0;
		res_valid = 1'b0;
		res_value = '0;
		res_status = status_q;
		res_last = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op_d = opcode;
					key_d = key;
					nv_d = new_value;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				status_d = ST_OK;
				case (op_q)
					OP_INSERT, OP_APPEND: begin
						if (!is_slot(free_q)) begin
							status_d = ST_FULL;
							state_d = S_RESP;
						end else begin
							req.re = 1'b1;
							req.raddr = free_q;
							slot_d = free_q;
							state_d = S_ALLOC_WR;
						end
					end
					OP_REMOVE, OP_TRAVERSE: begin
						if (op_q == OP_TRAVERSE && !is_slot(head_q)) begin
							status_d = ST_EMPTY;
							state_d = S_RESP;
						end else begin
							req.re = is_slot(head_q);
							req.raddr = head_q;
							cur_d = head_q;
							prev_d = NIL;
							cnt_d = '0;
							state_d = S_WALK;
						end
					end
					OP_CLEAR: begin
						if (is_slot(head_q) && is_slot(tail_q)) begin
							req.lwe = 1'b1;
							req.laddr = tail_q;
							req.ldata = free_q;
							free_d = head_q;
						end
						head_d = NIL;
						tail_d = NIL;
						state_d = S_RESP;
					end
					default: begin
						state_d = S_RESP;
					end
				endcase
			end
			S_ALLOC_WR: begin
				free_d = link_rdata;
				req.vwe = 1'b1;
				req.vaddr = slot_q;
				req.vdata = nv_q;
				req.lwe = 1'b1;
				req.laddr = slot_q;
				req.ldata = NIL;
				if (op_q == OP_INSERT) begin
					req.re = is_slot(head_q);
					req.raddr = head_q;
					cur_d = head_q;
					prev_d = NIL;
					cnt_d = '0;
					state_d = S_WALK;
				end else begin
					state_d = S_TAIL_LINK;
				end
			end
			S_WALK: begin
				if (op_q == OP_TRAVERSE) begin
					res_valid = 1'b1;
					res_value = value_rdata;
					res_status = ST_OK;
					res_last = fin;
					if (res_ready) begin
						if (fin) begin
							state_d = S_IDLE;
						end else begin
							req.re = 1'b1;
							req.raddr = link_rdata;
							cur_d = link_rdata;
							cnt_d = cnt_q + IW'(1);
						end
					end
				end else if (walk_end) begin
					if (op_q == OP_INSERT) begin
						state_d = S_TAIL_LINK;
					end else begin
						status_d = ST_NOTFOUND;
						state_d = S_RESP;
					end
				end else if (match) begin
					if (op_q == OP_INSERT) begin
						req.lwe = 1'b1;
						req.laddr = slot_q;
						req.ldata = cur_q;
						state_d = S_INS_LINK;
					end else begin
						// unlink the node, keep it for the free list
						if (is_slot(prev_q)) begin
							req.lwe = 1'b1;
							req.laddr = prev_q;
							req.ldata = link_rdata;
						end else begin
							head_d = link_rdata;
						end
						if (tail_q == cur_q) begin
							tail_d = prev_q;
						end
						state_d = S_REM_FREE;
					end
				end else begin
					req.re = is_slot(link_rdata);
					req.raddr = link_rdata;
					prev_d = cur_q;
					cur_d = link_rdata;
					cnt_d = cnt_q + IW'(1);
				end
			end
			S_INS_LINK: begin
				if (is_slot(prev_q)) begin
					req.lwe = 1'b1;
					req.laddr = prev_q;
					req.ldata = slot_q;
				end else begin
					head_d = slot_q;
				end
				state_d = S_RESP;
			end
			S_TAIL_LINK: begin
				if (is_slot(tail_q)) begin
					req.lwe = 1'b1;
					req.laddr = tail_q;
					req.ldata = slot_q;
				end else begin
					head_d = slot_q;
				end
				tail_d = slot_q;
				state_d = S_RESP;
			end
			S_REM_FREE: begin
				req.lwe = 1'b1;
				req.laddr = cur_q;
				req.ldata = free_q;
				free_d = cur_q;
				state_d = S_RESP;
			end
			S_RESP: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= NIL;
			tail_q <= NIL;
			free_q <= '0;
		end else begin
			state_q <= state_d;
			head_q <= head_d;
			tail_q <= tail_d;
			free_q <= free_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q <= op_d;
		key_q <= key_d;
		nv_q <= nv_d;
		cur_q <= cur_d;
		prev_q <= prev_d;
		slot_q <= slot_d;
		cnt_q <= cnt_d;
		status_q <= status_d;
	end

	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_DISPATCH))
		else $error("accepted item did not reach dispatch");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (cnt_q <= NIL))
		else $error("walk counter beyond pool size");

	a_value_write_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		req.vwe |-> (state_q == S_ALLOC_WR && is_slot(req.vaddr)))
		else $error("value write outside allocation");

	a_result_value: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_value != 32'd0) |-> (state_q == S_WALK && op_q == OP_TRAVERSE))
		else $error("nonzero value outside traverse");

endmodule

/* design/linked_list_manager_core.sv */
// Singly linked list of signed 32-bit values in a pool of DEPTH slots (package
// constant, 32 by default) with a link memory and a free list. One item is
// taken at a time; in_ready is high only while the sequencer is idle. Each
// walk visits one node per cycle, unless the output stalls a traverse,
// through the registered read port of the link and value memories, so the
// time of a traverse follows list length L, and that of remove and insert
// the number of nodes n visited before the key matches; append, clear and
// unknown opcodes do not walk. The link memory keeps one valid bit per
// slot, so it needs no clearing pass after reset and the block takes items
// right away. Results leave through a one-entry output register; a
// non-traverse item gives one result with last set, a traverse gives one
// result per element with last on the final one.
module linked_list_manager_core (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [2:0] opcode,
	input logic signed [31:0] key,
	input logic signed [31:0] new_value,
	output logic out_valid,
	input logic out_ready,
	output logic signed [31:0] out_value,
	output logic [1:0] status,
	output logic last
);
	import llm_pkg::*;

	mem_req_t req;
	logic [31:0] value_rdata;
	logic [IW-1:0] link_rdata;
	logic res_valid, res_ready, res_last;
	logic [31:0] res_value;
	logic [1:0] res_status;

	logic out_valid_q;
	logic [31:0] out_value_q;
	logic [1:0] status_q;
	logic last_q;

	llm_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.key(key),
		.new_value(new_value),
		.req(req),
		.value_rdata(value_rdata),
		.link_rdata(link_rdata),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_value(res_value),
		.res_status(res_status),
		.res_last(res_last)
	);

	llm_store u_store (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.value_rdata(value_rdata),
		.link_rdata(link_rdata)
	);

	// load a new result when the register is empty or its transfer completes
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	// hold the payload while a result waits
	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_value_q <= res_value;
			status_q <= res_status;
			last_q <= res_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign status = status_q;
	assign last = last_q;

endmodule
